// ----- src/tsd_pkg.sv -----
// Shared types and constants for the touch swipe detector.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

    localparam int COORD_W = 12;
    localparam int TIME_W  = 32;
    localparam int MIND_W  = 12;
    localparam int MAXD_W  = 16;
    localparam int CFG_W   = 16;

    localparam logic [MIND_W-1:0] MIN_DIST_RST = 12'd36;
    localparam logic [MAXD_W-1:0] MAX_DUR_RST  = 16'd900;

    // Request codes carried in req_type
    localparam logic REQ_TOUCH   = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    // Configuration register indexes
    localparam logic CFG_MIN_DIST = 1'b0;
    localparam logic CFG_MAX_DUR  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic               touch_present;
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic [TIME_W-1:0]  time_ms;
    } tsd_in_t;

    typedef struct packed {
        logic               gesture_valid;
        logic               gesture_dir;
        logic [COORD_W-1:0] gesture_x;
        logic [COORD_W-1:0] gesture_y;
    } tsd_out_t;

    typedef struct packed {
        logic [MIND_W-1:0] min_distance;
        logic [MAXD_W-1:0] max_duration;
    } tsd_cfg_t;

    // Swipe recognised on this word, headed for the mailbox
    typedef struct packed {
        logic               fire;
        logic               dir;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tsd_fire_t;

endpackage

`default_nettype wire

// ----- src/touch_swipe_detector.sv -----
// Top level of the touch swipe detector: input register, tracker and mailbox.
//
// Input channel (s_valid/s_ready/s_data): each word is either a touch sample
// (req_type 0) or a consume request (req_type 1). Samples produce no result;
// every consume request produces exactly one result word on the m_ channel,
// with gesture_valid set if a swipe was waiting in the mailbox.
// An accepted word waits in the input register and is processed from there; a
// consume result is loaded into the result register and presented on m_valid.
// Throughput: one word per cycle except in a stall. The input register and the
// result register part the two sides, so samples keep flowing while a result waits.
// Stall: while m_ready is low and a result is held, a consume request waits in
// the input register and s_ready drops; touch samples never wait.
// Configuration (cfg_we/cfg_index/cfg_wdata): write the minimum distance and
// maximum duration only while the block is idle.
// Reset (aresetn low, synchronous): clear the press, the mailbox and the
// result register; restore minimum distance 36 and maximum duration 900.
`timescale 1ns / 1ps
`default_nettype none

module touch_swipe_detector
    import tsd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tsd_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tsd_out_t              m_data,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic      in_valid_reg;
    tsd_in_t   in_word_reg;
    tsd_cfg_t  cfg_reg;
    tsd_fire_t fire;
    logic      slot_full, out_free, advance, step, consume;

    // Advance the held word unless it is a consume request facing a full result register
    assign advance = in_valid_reg && (in_word_reg.req_type != REQ_CONSUME || out_free);
    assign step    = advance && (in_word_reg.req_type == REQ_TOUCH);
    assign consume = advance && (in_word_reg.req_type == REQ_CONSUME);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Configuration registers: truncate write data to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_distance <= MIN_DIST_RST;
            cfg_reg.max_duration <= MAX_DUR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_DIST: cfg_reg.min_distance <= cfg_wdata[MIND_W-1:0];
                CFG_MAX_DUR:  cfg_reg.max_duration <= cfg_wdata[MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    tsd_track #(
        .COORD_BITS(COORD_BITS)
    ) u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .word     (in_word_reg),
        .cfg      (cfg_reg),
        .slot_full(slot_full),
        .fire_o   (fire)
    );

    tsd_mailbox u_mailbox (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire_i   (fire),
        .consume  (consume),
        .m_ready  (m_ready),
        .slot_full(slot_full),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

`ifndef ASSERT_OFF
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_word_reg))
        else $error("stalled input word lost");
`endif

endmodule

`default_nettype wire

// ----- src/tsd_track.sv -----
// Press tracker: start point, travel maxima and the swipe decision.
`timescale 1ns / 1ps
`default_nettype none

module tsd_track
    import tsd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step,
    input  wire tsd_in_t   word,
    input  wire tsd_cfg_t  cfg,
    input  wire logic      slot_full,
    output tsd_fire_t      fire_o
);

    localparam int CW    = COORD_BITS;
    localparam int CMP_W = (COORD_BITS > MIND_W) ? COORD_BITS : MIND_W;

    logic              pressed_reg, pressed_next;
    logic              fired_reg, fired_next;
    logic [TIME_W-1:0] press_time_reg;
    logic [CW-1:0]     start_x_reg, start_y_reg;
    logic [CW-1:0]     last_x_reg, last_y_reg;
    logic [CW-1:0]     max_dx_reg, max_dy_reg;

    logic [CW-1:0]     x_c, y_c, dx, dy, mdx, mdy, px, py;
    logic [TIME_W-1:0] elapsed;
    logic              held, release_s, qualify, fire;

    always_comb begin
        x_c       = CW'(word.touch_x);
        y_c       = CW'(word.touch_y);
        held      = word.touch_present && pressed_reg;
        release_s = !word.touch_present && pressed_reg;
        dx        = (x_c > start_x_reg) ? x_c - start_x_reg : start_x_reg - x_c;
        dy        = (y_c > start_y_reg) ? y_c - start_y_reg : start_y_reg - y_c;
        mdx       = max_dx_reg;
        mdy       = max_dy_reg;
        px        = last_x_reg;
        py        = last_y_reg;
        if (held) begin
            if (dx > max_dx_reg) begin
                mdx = dx;
            end
            if (dy > max_dy_reg) begin
                mdy = dy;
            end
            px = x_c;
            py = y_c;
        end
        elapsed = word.time_ms - press_time_reg;
        qualify = (held || release_s) && !fired_reg && !slot_full
                  && (elapsed <= TIME_W'(cfg.max_duration))
                  && (CMP_W'(mdx) >= CMP_W'(cfg.min_distance))
                  && (mdx >= mdy);
        fire    = step && qualify;

        fire_o.fire = fire;
        fire_o.dir  = (px > start_x_reg);
        fire_o.x    = COORD_W'(px);
        fire_o.y    = COORD_W'(py);

        pressed_next = pressed_reg;
        fired_next   = fired_reg || fire;
        if (step) begin
            if (!word.touch_present) begin
                pressed_next = 1'b0;
            end else if (!pressed_reg) begin
                pressed_next = 1'b1;
                fired_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            fired_reg   <= 1'b0;
        end else begin
            pressed_reg <= pressed_next;
            fired_reg   <= fired_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && word.touch_present) begin
            last_x_reg <= x_c;
            last_y_reg <= y_c;
            if (!pressed_reg) begin
                press_time_reg <= word.time_ms;
                start_x_reg    <= x_c;
                start_y_reg    <= y_c;
                max_dx_reg     <= '0;
                max_dy_reg     <= '0;
            end else begin
                max_dx_reg <= mdx;
                max_dy_reg <= mdy;
            end
        end
    end

`ifndef ASSERT_OFF
    a_fire_in_press: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> pressed_reg)
        else $error("swipe fired outside a press");
    a_fire_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> fired_reg)
        else $error("fired swipe not marked for the press");
`endif

endmodule

`default_nettype wire

// ----- src/tsd_mailbox.sv -----
// One-slot gesture mailbox and the result register.
`timescale 1ns / 1ps
`default_nettype none

module tsd_mailbox
    import tsd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire tsd_fire_t fire_i,
    input  wire logic      consume,
    input  wire logic      m_ready,
    output logic           slot_full,
    output logic           out_free,
    output logic           m_valid,
    output tsd_out_t       m_data
);

    logic               slot_full_reg;
    logic               slot_dir_reg;
    logic [COORD_W-1:0] slot_x_reg, slot_y_reg;
    logic               m_valid_reg;
    tsd_out_t           m_data_reg, m_data_next;

    assign slot_full = slot_full_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        m_data_next = '0;
        if (slot_full_reg) begin
            m_data_next.gesture_valid = 1'b1;
            m_data_next.gesture_dir   = slot_dir_reg;
            m_data_next.gesture_x     = slot_x_reg;
            m_data_next.gesture_y     = slot_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_full_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (consume) begin
                slot_full_reg <= 1'b0;
            end else if (fire_i.fire) begin
                slot_full_reg <= 1'b1;
            end
            if (consume) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_i.fire) begin
            slot_dir_reg <= fire_i.dir;
            slot_x_reg   <= fire_i.x;
            slot_y_reg   <= fire_i.y;
        end
        if (consume) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_i.fire |-> !slot_full_reg)
        else $error("swipe written over a full slot");
    a_consume_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        consume |=> !slot_full_reg && m_valid_reg)
        else $error("consume did not clear slot or load result");
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.gesture_valid) |->
        (!m_data_reg.gesture_dir && m_data_reg.gesture_x == '0
         && m_data_reg.gesture_y == '0))
        else $error("empty read-out carries nonzero fields");
`endif

endmodule

`default_nettype wire
